// File: rtl/core/rmn_pkg.sv
// shared constants and the uniform share table for the regret matching block
package rmn_pkg;

  localparam int REGRET_W   = 32;
  localparam int X_W        = REGRET_W - 1;
  localparam int PROB_W     = 17;
  localparam int THR_W      = 16;
  localparam int DIV_STEPS  = PROB_W;
  localparam int PRE_STAGES = 3;
  localparam int PIPE_DEPTH = PRE_STAGES + DIV_STEPS;
  localparam int CNT_W      = 5;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [APB_AW-1:0] ADDR_SMALL_THRESHOLD = 3'd0;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET      = 16'd1;

  // floor(65536 / n) for n legal actions up to 16, zero when none is legal or n is above 16
  function automatic logic [PROB_W-1:0] uniform_share(input logic [CNT_W-1:0] n);
    logic [PROB_W-1:0] s;
    case (n)
      5'd1:    s = 17'd65536;
      5'd2:    s = 17'd32768;
      5'd3:    s = 17'd21845;
      5'd4:    s = 17'd16384;
      5'd5:    s = 17'd13107;
      5'd6:    s = 17'd10922;
      5'd7:    s = 17'd9362;
      5'd8:    s = 17'd8192;
      5'd9:    s = 17'd7281;
      5'd10:   s = 17'd6553;
      5'd11:   s = 17'd5957;
      5'd12:   s = 17'd5461;
      5'd13:   s = 17'd5041;
      5'd14:   s = 17'd4681;
      5'd15:   s = 17'd4369;
      5'd16:   s = 17'd4096;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/regret_matching_normalize_top.sv
// top level of the regret matching normalizer
// Regret matching for one decision point: each input transfer carries NUM_ACTIONS signed
// Q16.16 regrets and a legal-action mask; positive legal regrets are summed and each is
// divided by the sum into Q1.16 probabilities, or the uniform share over legal actions is
// given when the sum is below small_threshold or zero (m_tuser then 1). Unless the output
// stalls, the block takes one transfer per cycle through 20 register stages: one clamp
// stage, a two-stage registered adder tree, and a 17-stage restoring divider in every
// lane, one quotient bit per stage. m_tvalid is the valid flag of the last divider stage.
// Stages hold their data under backpressure and bubbles close up.
module regret_matching_normalize_top #(
  parameter int NUM_ACTIONS = 9
) (
  input  logic clk,
  input  logic rst,
  // regret_0 .. regret_{N-1} (32 bits each), legal_mask (N bits), zero padding
  input  logic [((NUM_ACTIONS * (rmn_pkg::REGRET_W + 1) + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  // prob_0 .. prob_{N-1} (17 bits each), zero padding
  output logic [((NUM_ACTIONS * rmn_pkg::PROB_W + 7) / 8) * 8 - 1:0] m_tdata,
  // uniform_used
  output logic [0:0] m_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [rmn_pkg::APB_AW-1:0] paddr,
  input  logic [rmn_pkg::APB_DW-1:0] pwdata,
  output logic [rmn_pkg::APB_DW-1:0] prdata,
  output logic pready
);
  import rmn_pkg::*;

  localparam int SUM_W  = X_W + $clog2(NUM_ACTIONS);
  localparam int MASK_LO = NUM_ACTIONS * REGRET_W;
  localparam int OUT_W  = ((NUM_ACTIONS * PROB_W + 7) / 8) * 8;

  logic [THR_W-1:0]      small_threshold;
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] en;
  logic [X_W-1:0]        x     [NUM_ACTIONS];
  logic [PROB_W-1:0]     quo   [NUM_ACTIONS];
  logic                  lgo   [NUM_ACTIONS];
  logic [SUM_W-1:0]      sum_tree;
  logic [SUM_W-1:0]      sp    [DIV_STEPS];
  logic [SUM_W-1:0]      sp_q  [1:DIV_STEPS-1];
  logic                  fb    [DIV_STEPS];
  logic                  fb_next;
  logic [CNT_W-1:0]      legal_cnt;
  logic [PROB_W-1:0]     share;
  logic [OUT_W-1:0]      out_data;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SMALL_THRESHOLD) ? APB_DW'(small_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_SMALL_THRESHOLD)) begin
      small_threshold <= pwdata[THR_W-1:0];
    end
  end

  // per-stage load enables, a stage moves when it is empty or its successor moves
  always_comb begin
    en[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || m_tready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? s_tvalid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // lanes
  for (genvar j = 0; j < NUM_ACTIONS; j++) begin : g_lane
    rmn_lane #(
      .SUM_W(SUM_W)
    ) u_lane (
      .clk      (clk),
      .regret   (s_tdata[j * REGRET_W +: REGRET_W]),
      .legal    (s_tdata[MASK_LO + j]),
      .en       (en),
      .dvs      (sp),
      .x_out    (x[j]),
      .quo      (quo[j]),
      .legal_out(lgo[j])
    );
  end

  // merge of the clamped values
  rmn_sum #(
    .NUM  (NUM_ACTIONS),
    .SUM_W(SUM_W)
  ) u_sum (
    .clk(clk),
    .en (en[2:1]),
    .x  (x),
    .sum(sum_tree)
  );

  // divisor and fallback flag travel beside the divider stages
  assign fb_next = (sum_tree < SUM_W'(small_threshold)) || (sum_tree == '0);

  always_comb begin
    sp[0] = sum_tree;
    for (int d = 1; d < DIV_STEPS; d++) begin
      sp[d] = sp_q[d];
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < DIV_STEPS; d++) begin
      if (en[PRE_STAGES + d]) begin
        fb[d] <= (d == 0) ? fb_next : fb[(d == 0) ? 0 : d - 1];
      end
    end
    for (int d = 1; d < DIV_STEPS; d++) begin
      if (en[PRE_STAGES + d - 1]) begin
        sp_q[d] <= sp[d-1];
      end
    end
  end

  // uniform share from the count of legal actions at the output
  always_comb begin
    legal_cnt = '0;
    for (int j = 0; j < NUM_ACTIONS; j++) begin
      legal_cnt = legal_cnt + CNT_W'(lgo[j]);
    end
  end

  assign share = uniform_share(legal_cnt);

  always_comb begin
    out_data = '0;
    for (int j = 0; j < NUM_ACTIONS; j++) begin
      out_data[j * PROB_W +: PROB_W] = fb[DIV_STEPS-1] ? (lgo[j] ? share : '0) : quo[j];
    end
  end

  assign m_tdata  = out_data;
  assign m_tuser  = fb[DIV_STEPS-1];
  assign m_tvalid = vld[PIPE_DEPTH-1];

  // checks
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted transfer did not enter the first stage");

  a_zero_sum_fallback : assert property (@(posedge clk) disable iff (rst)
    vld[PRE_STAGES-1] && en[PRE_STAGES] && (sum_tree == '0) |=> fb[0])
    else $error("zero sum did not select the uniform share");

  a_prob_bound : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[PROB_W-1] |-> m_tdata[PROB_W-2:0] == '0)
    else $error("lane 0 probability above one");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    vld[PIPE_DEPTH-1] && !m_tready |=> vld[PIPE_DEPTH-1])
    else $error("pending result dropped under backpressure");

endmodule

// File: rtl/core/rmn_sum.sv
// registered two-level adder tree over the clamped regrets of all lanes
module rmn_sum #(
  parameter int NUM   = 9,
  parameter int SUM_W = 35
) (
  input  logic                    clk,
  input  logic [1:0]              en,
  input  logic [rmn_pkg::X_W-1:0] x [NUM],
  output logic [SUM_W-1:0]        sum
);
  import rmn_pkg::*;

  localparam int GROUPS = (NUM + 3) / 4;
  localparam int PART_W = X_W + 2;

  logic [PART_W-1:0] part      [GROUPS];
  logic [PART_W-1:0] part_next [GROUPS];
  logic [SUM_W-1:0]  sum_next;

  // first level: groups of four
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part_next[g] = '0;
      for (int i = 0; i < 4; i++) begin
        if (4 * g + i < NUM) begin
          part_next[g] = part_next[g] + PART_W'(x[4 * g + i]);
        end
      end
    end
  end

  // second level: the group partials
  always_comb begin
    sum_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      sum_next = sum_next + SUM_W'(part[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      part <= part_next;
    end
    if (en[1]) begin
      sum <= sum_next;
    end
  end

endmodule

// File: rtl/core/rmn_lane.sv
// one action lane: clamp, delay, and a pipelined restoring divider
module rmn_lane #(
  parameter int SUM_W = 35
) (
  input  logic                                clk,
  input  logic [rmn_pkg::REGRET_W-1:0]        regret,
  input  logic                                legal,
  input  logic [rmn_pkg::PIPE_DEPTH-1:0]      en,
  input  logic [SUM_W-1:0]                    dvs [rmn_pkg::DIV_STEPS],
  output logic [rmn_pkg::X_W-1:0]             x_out,
  output logic [rmn_pkg::PROB_W-1:0]          quo,
  output logic                                legal_out
);
  import rmn_pkg::*;

  logic [X_W-1:0]    x0, x1, x2;
  logic              lg0, lg1, lg2;
  logic [X_W-1:0]    x0_next;
  logic [SUM_W-1:0]  rem      [DIV_STEPS];
  logic [SUM_W-1:0]  rem_next [DIV_STEPS];
  logic [PROB_W-1:0] q        [DIV_STEPS];
  logic [PROB_W-1:0] q_next   [DIV_STEPS];
  logic              lg       [DIV_STEPS];
  logic [SUM_W:0]    trial    [DIV_STEPS];
  logic [SUM_W:0]    diff     [DIV_STEPS];
  logic              ge       [DIV_STEPS];

  // clamp at zero and drop illegal actions
  assign x0_next = (legal && !regret[REGRET_W-1] && (regret != '0)) ?
                   regret[X_W-1:0] : '0;

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int d = 0; d < DIV_STEPS; d++) begin
      if (d == 0) begin
        trial[d] = (SUM_W + 1)'(x2);
      end else begin
        trial[d] = {rem[d-1], 1'b0};
      end
      diff[d] = trial[d] - {1'b0, dvs[d]};
      ge[d]   = trial[d] >= {1'b0, dvs[d]};
      rem_next[d] = ge[d] ? diff[d][SUM_W-1:0] : trial[d][SUM_W-1:0];
      if (d == 0) begin
        q_next[d] = PROB_W'(ge[d]);
      end else begin
        q_next[d] = {q[d-1][PROB_W-2:0], ge[d]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0  <= x0_next;
      lg0 <= legal;
    end
    if (en[1]) begin
      x1  <= x0;
      lg1 <= lg0;
    end
    if (en[2]) begin
      x2  <= x1;
      lg2 <= lg1;
    end
    for (int d = 0; d < DIV_STEPS; d++) begin
      if (en[PRE_STAGES + d]) begin
        rem[d] <= rem_next[d];
        q[d]   <= q_next[d];
        lg[d]  <= (d == 0) ? lg2 : lg[(d == 0) ? 0 : d - 1];
      end
    end
  end

  assign x_out     = x0;
  assign quo       = q[DIV_STEPS-1];
  assign legal_out = lg[DIV_STEPS-1];

endmodule
